@@ rtl/core/iocc_pkg.sv @@
// ----------------------------------------------------------------------------
// iocc_pkg
// Types and constants shared by the IMU offset calibrate/correct unit.
// ----------------------------------------------------------------------------
package iocc_pkg;

    localparam int AXIS_W        = 16;
    localparam int NUM_AXES      = 6;
    localparam int CAL_COUNT_DEF = 128;

    // axis order: ax, ay, az, gx, gy, gz
    localparam int AXIS_ACCEL_Z  = 2;

    // 1 g in accelerometer counts
    localparam logic [AXIS_W-1:0] ONE_G = AXIS_W'(16'hFFFF >> 2);

    typedef enum logic
    {
        REQ_MEASURE = 1'b0,
        REQ_CAL     = 1'b1
    } req_type_t;

    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef struct packed
    {
        req_type_t req_type;
        axis_t     accel_x;
        axis_t     accel_y;
        axis_t     accel_z;
        axis_t     gyro_x;
        axis_t     gyro_y;
        axis_t     gyro_z;
    } sample_t;

    typedef struct packed
    {
        axis_t corr_accel_x;
        axis_t corr_accel_y;
        axis_t corr_accel_z;
        axis_t corr_gyro_x;
        axis_t corr_gyro_y;
        axis_t corr_gyro_z;
        logic  cal_done;
    } result_t;

    // pipeline control from the sequencer to every lane
    typedef struct packed
    {
        logic load;     // word accepted this cycle
        logic cal;      // accepted word is a calibration sample
        logic finish;   // accepted word completes a run
        logic adv1;     // stage 1 -> stage 2
        logic adv2;     // stage 2 -> stage 3
        logic adv3;     // stage 3 -> output register
        logic finish3;  // word in stage 3 completed a run
    } ctrl_t;

endpackage

@@ rtl/core/imu_offset_calibrate_correct_unit.sv @@
// ----------------------------------------------------------------------------
// imu_offset_calibrate_correct_unit
// Six-axis IMU offset correction with averaging bias calibration.
// ----------------------------------------------------------------------------
//   channel  | handshake                   | word
//   ---------+-----------------------------+---------------------------------
//   sample   | sample_valid / sample_stall | sample_t: req_type, 6 raw axes
//   result   | result_valid / result_stall | result_t: 6 corrected, cal_done
//
// One word per cycle sustained while result_stall is low; a result is registered
// through the lane stages for running sum, abs and reciprocal multiply, the last
// one feeding the offset update as it loads the output register.
// Reset clears sums, offsets, sample count and valids.
// result_stall backs up the pipeline; sample_stall rises only with all
// stages and the output register full.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_correct_unit
    import iocc_pkg::*;
#(
    parameter int CAL_COUNT = CAL_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    ctrl_t   ctrl;
    axis_t   raw_axes  [NUM_AXES];
    axis_t   corr_axes [NUM_AXES];
    result_t result_reg;

    iocc_ctrl #(
        .CAL_COUNT (CAL_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .req_type     (sample.req_type),
        .sample_stall (sample_stall),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .ctrl         (ctrl)
    );

    assign raw_axes[0] = sample.accel_x;
    assign raw_axes[1] = sample.accel_y;
    assign raw_axes[2] = sample.accel_z;
    assign raw_axes[3] = sample.gyro_x;
    assign raw_axes[4] = sample.gyro_y;
    assign raw_axes[5] = sample.gyro_z;

    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_lane
        iocc_lane #(
            .CAL_COUNT (CAL_COUNT),
            .GRAV_AXIS (i == AXIS_ACCEL_Z)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .raw   (raw_axes[i]),
            .corr  (corr_axes[i])
        );
    end

    // merge lanes into the output word
    always_ff @(posedge clk)
    begin
        if (ctrl.adv3)
        begin
            result_reg.corr_accel_x <= corr_axes[0];
            result_reg.corr_accel_y <= corr_axes[1];
            result_reg.corr_accel_z <= corr_axes[2];
            result_reg.corr_gyro_x  <= corr_axes[3];
            result_reg.corr_gyro_y  <= corr_axes[4];
            result_reg.corr_gyro_z  <= corr_axes[5];
            result_reg.cal_done     <= ctrl.finish3;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/core/iocc_ctrl.sv @@
// ----------------------------------------------------------------------------
// iocc_ctrl
// Sample counter and valid tracking for the three-stage lane pipeline and
// the output register; produces the stage advance strobes.
// ----------------------------------------------------------------------------
module iocc_ctrl
    import iocc_pkg::*;
#(
    parameter int CAL_COUNT = CAL_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    input  req_type_t req_type,
    output logic      sample_stall,
    input  logic      result_stall,
    output logic      result_valid,
    output ctrl_t     ctrl
);

    localparam int CNT_W = $clog2(CAL_COUNT + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic v1_next, v2_next, v3_next, out_valid_next;
    logic fin1_reg, fin2_reg, fin3_reg;

    logic out_free, s3_free, s2_free, s1_free;

    always_comb
    begin
        out_free = !out_valid_reg || !result_stall;
        s3_free  = !v3_reg || out_free;
        s2_free  = !v2_reg || s3_free;
        s1_free  = !v1_reg || s2_free;

        cnt_inc = cnt_reg + 1'b1;

        ctrl.load    = sample_valid && s1_free;
        ctrl.cal     = (req_type == REQ_CAL);
        ctrl.finish  = ctrl.cal && (cnt_inc == CNT_W'(CAL_COUNT));
        ctrl.adv1    = v1_reg && s2_free;
        ctrl.adv2    = v2_reg && s3_free;
        ctrl.adv3    = v3_reg && out_free;
        ctrl.finish3 = fin3_reg;

        cnt_next = cnt_reg;
        if (ctrl.load && ctrl.cal)
        begin
            cnt_next = ctrl.finish ? '0 : cnt_inc;
        end

        v1_next        = ctrl.load || (v1_reg && !ctrl.adv1);
        v2_next        = ctrl.adv1 || (v2_reg && !ctrl.adv2);
        v3_next        = ctrl.adv2 || (v3_reg && !ctrl.adv3);
        out_valid_next = ctrl.adv3 || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            fin1_reg      <= 1'b0;
            fin2_reg      <= 1'b0;
            fin3_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
            if (ctrl.load)
            begin
                fin1_reg <= ctrl.finish;
            end
            if (ctrl.adv1)
            begin
                fin2_reg <= fin1_reg;
            end
            if (ctrl.adv2)
            begin
                fin3_reg <= fin2_reg;
            end
        end
    end

    assign sample_stall = !s1_free;
    assign result_valid = out_valid_reg;

endmodule

@@ rtl/core/iocc_lane.sv @@
// ----------------------------------------------------------------------------
// iocc_lane
// One axis: running sum, divide-by-count through a constant reciprocal,
// stored offset and offset subtraction.
// ----------------------------------------------------------------------------
module iocc_lane
    import iocc_pkg::*;
#(
    parameter int   CAL_COUNT = CAL_COUNT_DEF,
    parameter logic GRAV_AXIS = 1'b0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  axis_t raw,
    output axis_t corr
);

    localparam int DIV_LOG = $clog2(CAL_COUNT);
    localparam int SUM_W   = AXIS_W + DIV_LOG;
    localparam int MAG_W   = SUM_W;
    localparam int RCP_W   = MAG_W + 1;
    localparam int DIV_SH  = MAG_W + DIV_LOG;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam int Q_W     = PROD_W - DIV_SH;

    // ceil(2^DIV_SH / CAL_COUNT): exact quotient for any magnitude below 2^MAG_W
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << DIV_SH) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT));

    localparam logic [AXIS_W-1:0] GRAV_OFS = GRAV_AXIS ? ONE_G : '0;
    localparam logic [AXIS_W-1:0] ADJ_POS  = AXIS_W'(0) - GRAV_OFS;
    localparam logic [AXIS_W-1:0] ADJ_NEG  = AXIS_W'(1) - GRAV_OFS;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_add;

    axis_t                   raw1_reg, raw2_reg, raw3_reg;
    logic signed [SUM_W-1:0] tot1_reg;
    logic                    neg2_reg, neg3_reg;
    logic [MAG_W-1:0]        mag2_reg;
    logic [MAG_W-1:0]        mag_next;
    logic [PROD_W-1:0]       prod3_reg;
    logic [PROD_W-1:0]       prod_next;

    logic [Q_W-1:0]          quot_full;
    logic [AXIS_W-1:0]       quot;
    logic [AXIS_W-1:0]       ofs_base;
    logic [AXIS_W-1:0]       ofs_adj;
    logic [AXIS_W-1:0]       offset_reg;
    logic [AXIS_W-1:0]       offset_next;

    always_comb
    begin
        sum_add  = sum_reg + SUM_W'(raw);
        sum_next = sum_reg;
        if (ctrl.load && ctrl.cal)
        begin
            sum_next = ctrl.finish ? '0 : sum_add;
        end

        // two's complement negate also covers the most negative sum
        mag_next  = tot1_reg[SUM_W-1] ? MAG_W'(-tot1_reg) : MAG_W'(tot1_reg);
        prod_next = PROD_W'(mag2_reg) * PROD_W'(RECIP);

        quot_full = prod3_reg[PROD_W-1:DIV_SH];
        quot      = quot_full[AXIS_W-1:0];

        // -q - g = ~q + (1 - g)
        ofs_base    = neg3_reg ? ~quot : quot;
        ofs_adj     = neg3_reg ? ADJ_NEG : ADJ_POS;
        offset_next = ofs_base + ofs_adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (ctrl.adv3 && ctrl.finish3)
            begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            raw1_reg <= raw;
            tot1_reg <= sum_add;
        end
        if (ctrl.adv1)
        begin
            raw2_reg <= raw1_reg;
            neg2_reg <= tot1_reg[SUM_W-1];
            mag2_reg <= mag_next;
        end
        if (ctrl.adv2)
        begin
            raw3_reg  <= raw2_reg;
            neg3_reg  <= neg2_reg;
            prod3_reg <= prod_next;
        end
    end

    // offset is read as the word leaves stage 3, in step with its update
    assign corr = axis_t'(raw3_reg - offset_reg);

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the IMU offset calibrate/correct unit: every word's six corrected
// axes and done flag against a cycle-free predictor of offsets and running
// sums, under random sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench
    import iocc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAL_RUN      = CAL_COUNT_DEF;
    localparam int HOLD_OFF_LEN = 64;
    localparam int DRAIN_CYCLES = 12;

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    imu_offset_calibrate_correct_unit #(.CAL_COUNT(CAL_RUN)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predictor state: axis order ax, ay, az, gx, gy, gz
    logic [AXIS_W-1:0] axis_offset [NUM_AXES];
    int                axis_sum    [NUM_AXES];
    int                cal_taken;

    result_t expected_results [$];
    result_t expected_word;

    int  mismatches;
    int  results_checked;
    int  measure_words;
    int  cal_words;
    int  runs_completed;
    int  input_stall_cycles;
    int  hold_off_requests;
    int  burst_left;
    bit  sender_gaps_on;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // works out the result of one accepted word and updates offsets and sums
    task automatic predict_correction(input sample_t s);
        axis_t   raw [NUM_AXES];
        axis_t   corr [NUM_AXES];
        result_t r;
        int      q;

        raw[0] = s.accel_x;
        raw[1] = s.accel_y;
        raw[2] = s.accel_z;
        raw[3] = s.gyro_x;
        raw[4] = s.gyro_y;
        raw[5] = s.gyro_z;
        for (int i = 0; i < NUM_AXES; i++)
            corr[i] = raw[i] - axis_offset[i];
        r.cal_done = 1'b0;

        if (s.req_type == REQ_CAL)
        begin
            cal_words++;
            for (int i = 0; i < NUM_AXES; i++)
                axis_sum[i] += int'(raw[i]);
            cal_taken++;
            if (cal_taken >= CAL_RUN)
            begin
                // new offsets take effect from the next word on
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    q = axis_sum[i] / CAL_RUN;
                    if (i == AXIS_ACCEL_Z)
                        q -= int'(ONE_G);
                    axis_offset[i] = q[AXIS_W-1:0];
                    axis_sum[i] = 0;
                end
                cal_taken = 0;
                r.cal_done = 1'b1;
                runs_completed++;
            end
        end
        else
            measure_words++;

        r.corr_accel_x = corr[0];
        r.corr_accel_y = corr[1];
        r.corr_accel_z = corr[2];
        r.corr_gyro_x  = corr[3];
        r.corr_gyro_y  = corr[4];
        r.corr_gyro_z  = corr[5];
        expected_results.push_back(r);
    endtask

    // drives one word at the falling edge and waits until it is taken
    task automatic send_word(input sample_t s);
        int gap;

        if (sender_gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                repeat (gap)
                begin
                    @(negedge clk);
                    sample_valid <= 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
        predict_correction(s);
    endtask

    task automatic go_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    function automatic axis_t pick_axis();
        case ($urandom_range(0, 9))
            0:       return axis_t'(16'h7FFF);
            1:       return axis_t'(16'h8000);
            2, 3, 4: return axis_t'($urandom_range(0, 511)) - axis_t'(256);
            default: return axis_t'($urandom());
        endcase
    endfunction

    function automatic sample_t make_word(input req_type_t kind);
        sample_t s;

        s.req_type = kind;
        s.accel_x  = pick_axis();
        s.accel_y  = pick_axis();
        s.accel_z  = pick_axis();
        s.gyro_x   = pick_axis();
        s.gyro_y   = pick_axis();
        s.gyro_z   = pick_axis();
        return s;
    endfunction

    function automatic sample_t uniform_word(input req_type_t kind, input axis_t v);
        return '{kind, v, v, v, v, v, v};
    endfunction

    // extremes with zero offsets, both kinds, measure words inside a run
    task automatic test_directed();
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h0000)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h7FFF)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h8000)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'hFFFF)));
        send_word('{REQ_MEASURE, 16'sh5555, 16'shAAAA, 16'sh5555,
                    16'shAAAA, 16'sh5555, 16'shAAAA});
        send_word('{REQ_MEASURE, 16'shAAAA, 16'sh5555, 16'shAAAA,
                    16'sh5555, 16'shAAAA, 16'sh5555});
        send_word(uniform_word(REQ_CAL, axis_t'(16'h7FFF)));
        send_word(uniform_word(REQ_CAL, axis_t'(16'h8000)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h0001)));
        send_word('{REQ_CAL, 16'sh7FFF, 16'sh8000, 16'sh0001,
                    16'shFFFF, 16'sh0000, 16'sh4000});
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h8001)));
        send_word(uniform_word(REQ_CAL, axis_t'(16'hFFFF)));
        send_word(uniform_word(REQ_CAL, axis_t'(16'h0000)));
        for (int i = 0; i < 8; i++)
            send_word(make_word(req_type_t'(i[0])));
    endtask

    // one aligned run with extreme sums, odd quotients and the 1 g wrap,
    // measure words sprinkled in, then extremes against the new offsets
    task automatic test_extreme_run();
        sample_t s;

        while (cal_taken != 0)
            send_word(make_word(REQ_CAL));
        for (int i = 0; i < CAL_RUN; i++)
        begin
            s.req_type = REQ_CAL;
            s.accel_x  = i[0] ? axis_t'(16'h7FFF) : axis_t'(16'h8000);
            s.accel_y  = axis_t'(16'h8000);
            s.accel_z  = axis_t'(16'h8000);
            s.gyro_x   = axis_t'(16'h7FFF);
            s.gyro_y   = (i == 0) ? axis_t'(16'h0000) : axis_t'(16'hFFFF);
            s.gyro_z   = pick_axis();
            send_word(s);
            if ($urandom_range(0, 15) == 0)
                send_word(make_word(REQ_MEASURE));
        end
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h7FFF)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h8000)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'h0000)));
        send_word(uniform_word(REQ_MEASURE, axis_t'(16'hFFFF)));
    endtask

    // mostly calibration words so that calibration runs complete
    task automatic test_random_mix(input int count);
        sample_t s;
        axis_t   bias [NUM_AXES];

        for (int i = 0; i < NUM_AXES; i++)
            bias[i] = pick_axis();
        for (int n = 0; n < count; n++)
        begin
            s = make_word(($urandom_range(0, 99) < 70) ? REQ_CAL : REQ_MEASURE);
            // realistic still sensor: a bias plus a little noise
            if ($urandom_range(0, 2) != 0)
            begin
                s.accel_x = bias[0] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
                s.accel_y = bias[1] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
                s.accel_z = bias[2] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
                s.gyro_x  = bias[3] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
                s.gyro_y  = bias[4] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
                s.gyro_z  = bias[5] + axis_t'($urandom_range(0, 63)) - axis_t'(32);
            end
            if (n == count / 2)
                sender_gaps_on = 1'b0;
            if (n == count / 2 + 60)
                sender_gaps_on = 1'b1;
            send_word(s);
        end
    endtask

    // receiver holds off while words keep coming, so the input backs up
    task automatic test_hold_off();
        sender_gaps_on = 1'b0;
        hold_off_requests++;
        for (int n = 0; n < 40; n++)
            send_word(make_word(req_type_t'($urandom_range(0, 1))));
        sender_gaps_on = 1'b1;
    endtask

    // receiver stall pattern; switches between quiet, sparse and heavy
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int holds_served;

        mode         = 0;
        mode_left    = 40;
        hold_left    = 0;
        holds_served = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_off_requests)
            begin
                holds_served = hold_off_requests;
                hold_left    = HOLD_OFF_LEN;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (mode == 1)
                result_stall <= ($urandom_range(0, 4) == 0);
            else if (mode == 2)
                result_stall <= ($urandom_range(0, 1) == 0);
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_stall)
                input_stall_cycles++;
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("word with nothing expected, cal_done", result.cal_done, 0);
                else
                begin
                    expected_word = expected_results.pop_front();
                    results_checked++;
                    compare_field("corr_accel_x", result.corr_accel_x,
                                  expected_word.corr_accel_x);
                    compare_field("corr_accel_y", result.corr_accel_y,
                                  expected_word.corr_accel_y);
                    compare_field("corr_accel_z", result.corr_accel_z,
                                  expected_word.corr_accel_z);
                    compare_field("corr_gyro_x", result.corr_gyro_x,
                                  expected_word.corr_gyro_x);
                    compare_field("corr_gyro_y", result.corr_gyro_y,
                                  expected_word.corr_gyro_y);
                    compare_field("corr_gyro_z", result.corr_gyro_z,
                                  expected_word.corr_gyro_z);
                    compare_field("cal_done", result.cal_done, expected_word.cal_done);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d words outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        sender_gaps_on = 1'b1;
        burst_left     = 0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            axis_offset[i] = '0;
            axis_sum[i]    = 0;
        end
        cal_taken = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mix(130);
        test_hold_off();
        test_extreme_run();
        test_random_mix(160);
        go_idle();

        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("words never returned", expected_results.size(), 0);

        $display("checked %0d words: %0d measure, %0d calibration, %0d runs completed",
                 results_checked, measure_words, cal_words, runs_completed);
        $display("input held back for %0d cycles; %0d mismatches",
                 input_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/iocc_pkg.sv
rtl/core/iocc_ctrl.sv
rtl/core/iocc_lane.sv
rtl/core/imu_offset_calibrate_correct_unit.sv
verif/testbench.sv
